/* rtl/assert_macros.svh */
// Assertion macros shared by the rmvp RTL.
// No dependencies; simulation builds get the checks, SYNTH builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RMVP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RMVP_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RMVP_ASSERT(lbl, clk, rstn, prop, msg)
`define RMVP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/rmvp_pkg.sv */
// Package for the rotation matrix vector projection block.
// Sizes, command and result types shared by all rmvp modules; no dependencies.
`default_nettype none

package rmvp_pkg;

  localparam int DIM        = 64;
  localparam int DATA_WIDTH = 16;

  localparam int IDX_W       = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int FIELD_IDX_W = 6;
  localparam int COEF_W      = 16;
  localparam int DIMS_W      = 7;
  localparam int OUT_W       = 38;
  localparam int PROD_W      = COEF_W + DATA_WIDTH;
  localparam int COEF_DEPTH  = DIM * DIM;
  localparam int CADDR_W     = $clog2(COEF_DEPTH);

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam int RQ_DEPTH = 2;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic [FIELD_IDX_W:0] IDX_LIMIT  = (FIELD_IDX_W + 1)'(DIM);
  localparam logic [DIMS_W-1:0]    DIMS_RESET = 7'd64;
  localparam logic [DIMS_W-1:0]    DIMS_MAX   = DIMS_W'(DIM);

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_NOT_LOADED = 1'b1;

  typedef enum logic {
    REQ_COEF = 1'b0,
    REQ_VEC  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    RUN_NONE,
    RUN_MAC,
    RUN_ERR
  } run_e;

  typedef struct packed {
    req_e              op;
    logic              wr_en;
    run_e              run;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [COEF_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cq_stat_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0] index;
    logic [OUT_W-1:0]       value;
    logic                   status;
    logic                   end_of_run;
  } result_t;

endpackage

`default_nettype wire

/* rtl/rmvp_cmd_fifo.sv */
// Short command queue between the rmvp front and back ends.
// Uses rmvp_pkg for cmd_t, cq_stat_t and the queue depth.
`default_nettype none

module rmvp_cmd_fifo import rmvp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire cmd_t     cmd_i,
  input  wire logic     pop_i,
  output cmd_t          cmd_o,
  output cq_stat_t      stat_o
);

  cmd_t                mem_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/rmvp_front.sv */
// Front end of rmvp: takes input beats, range-checks them, tracks whether any
// coefficient was loaded and turns each beat into a command. Uses rmvp_pkg.
`default_nettype none

module rmvp_front import rmvp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire logic                    req_type_i,
  input  wire logic [FIELD_IDX_W-1:0]  row_i,
  input  wire logic [FIELD_IDX_W-1:0]  col_i,
  input  wire logic signed [COEF_W-1:0] value_i,
  input  wire logic                    last_i,
  input  wire cq_stat_t                cq_stat_i,
  output logic                         full_o,
  output logic                         cq_push_o,
  output cmd_t                         cq_cmd_o
);

  logic loaded_q, loaded_d;
  logic accept, is_vec, row_ok, col_ok;

  assign full_o    = cq_stat_i.full;
  assign accept    = push_i & ~cq_stat_i.full;
  assign cq_push_o = accept;
  assign is_vec    = (req_e'(req_type_i) == REQ_VEC);
  assign row_ok    = ({1'b0, row_i} < IDX_LIMIT);
  assign col_ok    = ({1'b0, col_i} < IDX_LIMIT);

  always_comb begin
    cq_cmd_o.op    = req_e'(req_type_i);
    cq_cmd_o.wr_en = is_vec ? col_ok : (row_ok & col_ok);
    cq_cmd_o.row   = IDX_W'(row_i);
    cq_cmd_o.col   = IDX_W'(col_i);
    cq_cmd_o.data  = $unsigned(value_i);
    if (is_vec && last_i) begin
      cq_cmd_o.run = loaded_q ? RUN_MAC : RUN_ERR;
    end else begin
      cq_cmd_o.run = RUN_NONE;
    end
  end

  assign loaded_d = loaded_q | (accept & ~is_vec & row_ok & col_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/rmvp_back.sv */
// Back end of rmvp: coefficient and vector memories, the dims register,
// one pipelined MAC walking rows and columns, and a small result queue.
// Uses rmvp_pkg.
`default_nettype none

module rmvp_back import rmvp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DIMS_W-1:0] cfg_wdata_i,
  input  wire cmd_t              cq_cmd_i,
  input  wire cq_stat_t          cq_stat_i,
  output logic                   cq_pop_o,
  output result_t                res_o,
  output logic                   res_empty_o,
  input  wire logic              res_pop_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ERR
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] row_q, row_d, col_q, col_d, nlast_q, nlast_d;
  logic [IDX_W-1:0] dims_last;
  logic [DIMS_W-1:0] dims_q;

  logic [COEF_W-1:0]     coef_mem [COEF_DEPTH];
  logic [DATA_WIDTH-1:0] vec_mem  [DIM];
  logic [COEF_W-1:0]     coef_rd_q;
  logic [DATA_WIDTH-1:0] vec_rd_q;
  logic                  coef_we, vec_we;
  logic [CADDR_W-1:0]    coef_waddr, coef_raddr;

  logic                     adv, iss, row_end;
  logic                     s1_vld_q, s1_first_q, s1_last_q, s1_end_q;
  logic [IDX_W-1:0]         s1_row_q;
  logic                     s2_vld_q, s2_first_q, s2_last_q, s2_end_q;
  logic [IDX_W-1:0]         s2_row_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [OUT_W-1:0]  acc_q, acc_d;

  result_t             rq_mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] rq_wr_q, rq_rd_q;
  logic [RQ_CNT_W-1:0] rq_cnt_q, rq_cnt_d;
  logic                rq_full, rq_push, rq_pop, mac_push, err_push;
  result_t             rq_wdata;

  // active_dims: zero acts as one, anything above DIM as DIM
  always_comb begin
    if (dims_q == '0) begin
      dims_last = '0;
    end else if (dims_q > DIMS_MAX) begin
      dims_last = IDX_W'(DIM - 1);
    end else begin
      dims_last = IDX_W'(dims_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
    end else if (cfg_we_i) begin
      dims_q <= cfg_wdata_i;
    end
  end

  assign cq_pop_o = (state_q == ST_IDLE) & ~cq_stat_i.empty;
  assign iss      = (state_q == ST_ISSUE);
  assign row_end  = (col_q == nlast_q);
  assign adv      = ~(s2_vld_q & s2_last_q & rq_full);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    nlast_d = nlast_q;
    case (state_q)
      ST_IDLE: begin
        if (cq_pop_o) begin
          case (cq_cmd_i.run)
            RUN_MAC: begin
              state_d = ST_ISSUE;
              row_d   = '0;
              col_d   = '0;
              nlast_d = dims_last;
            end
            RUN_ERR: state_d = ST_ERR;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ISSUE: begin
        if (adv) begin
          if (row_end) begin
            col_d = '0;
            row_d = row_q + 1'b1;
            if (row_q == nlast_q) begin
              state_d = ST_DRAIN;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (!rq_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      nlast_q <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      nlast_q <= nlast_d;
    end
  end

  // memories
  assign coef_we    = cq_pop_o & (cq_cmd_i.op == REQ_COEF) & cq_cmd_i.wr_en;
  assign vec_we     = cq_pop_o & (cq_cmd_i.op == REQ_VEC) & cq_cmd_i.wr_en;
  assign coef_waddr = CADDR_W'(int'(cq_cmd_i.row) * DIM + int'(cq_cmd_i.col));
  assign coef_raddr = CADDR_W'(int'(row_q) * DIM + int'(col_q));

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= cq_cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      coef_rd_q <= coef_mem[coef_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[cq_cmd_i.col] <= DATA_WIDTH'(cq_cmd_i.data);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec_rd_q <= vec_mem[col_q];
    end
  end

  // MAC pipeline: read, multiply, accumulate
  assign acc_d = (s2_first_q ? OUT_W'(0) : acc_q) + OUT_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= iss;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_first_q <= (col_q == '0);
      s1_last_q  <= row_end;
      s1_end_q   <= (row_q == nlast_q);
      s1_row_q   <= row_q;
      prod_q     <= $signed(coef_rd_q) * $signed(vec_rd_q);
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_end_q   <= s1_end_q;
      s2_row_q   <= s1_row_q;
      if (s2_vld_q) begin
        acc_q <= acc_d;
      end
    end
  end

  // result queue
  assign rq_full     = (rq_cnt_q == RQ_CNT_W'(RQ_DEPTH));
  assign res_empty_o = (rq_cnt_q == '0);
  assign rq_pop      = res_pop_i & ~res_empty_o;
  assign mac_push    = s2_vld_q & s2_last_q & ~rq_full;
  assign err_push    = (state_q == ST_ERR) & ~rq_full;
  assign rq_push     = mac_push | err_push;
  assign res_o       = rq_mem_q[rq_rd_q];

  always_comb begin
    if (err_push) begin
      rq_wdata.index      = '0;
      rq_wdata.value      = '0;
      rq_wdata.status     = STATUS_NOT_LOADED;
      rq_wdata.end_of_run = 1'b1;
    end else begin
      rq_wdata.index      = FIELD_IDX_W'(s2_row_q);
      rq_wdata.value      = $unsigned(acc_d);
      rq_wdata.status     = STATUS_OK;
      rq_wdata.end_of_run = s2_end_q;
    end
  end

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (rq_push && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + 1'b1;
    end else if (!rq_push && rq_pop) begin
      rq_cnt_d = rq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
      if (rq_push) begin
        rq_wr_q <= rq_wr_q + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_q <= rq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_mem_q[rq_wr_q] <= rq_wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/rotation_matrix_vector_projection.sv */
// Rotation matrix vector projection: y = M * x with a stored square matrix.
// Input queue side: push/full. Each beat either loads one Q1.15 coefficient
//   (req_type 0, at row/col) or one vector element (req_type 1, at col).
//   A write beat is accepted whenever full is low; a 4-deep command queue sits
//   between the input decode and the MAC engine.
// Result queue side: empty/pop. A vector beat with last set runs the
//   projection: one result per active row, in row order, end_of_run on the
//   final row. Without any coefficient loaded a single status=1 result comes out.
// Engine: one shared multiply-accumulate handles one coefficient per cycle while
//   the MAC pipeline is not held; a projection over n active dims walks the
//   n-by-n coefficient block row by row through read and multiply registers.
// Stall: with a row result ready and the two-entry result queue full the MAC
//   pipeline holds; commands back up and full rises once the command queue fills.
// Reset: queues empty, active_dims = 64, no matrix loaded. Coefficient and
//   vector memories hold garbage until written.
// cfg_we_i/cfg_wdata_i write active_dims; only while the block is idle.
// Depends on rmvp_pkg, rmvp_front, rmvp_cmd_fifo, rmvp_back, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rotation_matrix_vector_projection import rmvp_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [DIMS_W-1:0]         cfg_wdata_i,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      req_type_i,
  input  wire logic [FIELD_IDX_W-1:0]    row_i,
  input  wire logic [FIELD_IDX_W-1:0]    col_i,
  input  wire logic signed [COEF_W-1:0]  value_i,
  input  wire logic                      last_i,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [FIELD_IDX_W-1:0]         out_index_o,
  output logic signed [OUT_W-1:0]        out_value_o,
  output logic                           status_o,
  output logic                           end_of_run_o
);

  cq_stat_t cq_stat;
  cmd_t     fe_cmd, cq_cmd;
  logic     fe_push, cq_pop;
  result_t  res;

  rmvp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .req_type_i (req_type_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (value_i),
    .last_i     (last_i),
    .cq_stat_i  (cq_stat),
    .full_o     (full),
    .cq_push_o  (fe_push),
    .cq_cmd_o   (fe_cmd)
  );

  rmvp_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_push),
    .cmd_i  (fe_cmd),
    .pop_i  (cq_pop),
    .cmd_o  (cq_cmd),
    .stat_o (cq_stat)
  );

  rmvp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cq_cmd_i    (cq_cmd),
    .cq_stat_i   (cq_stat),
    .cq_pop_o    (cq_pop),
    .res_o       (res),
    .res_empty_o (empty),
    .res_pop_i   (pop)
  );

  assign out_index_o  = res.index;
  assign out_value_o  = $signed(res.value);
  assign status_o     = res.status;
  assign end_of_run_o = res.end_of_run;

  `RMVP_ASSERT(a_err_last, clk_i, rst_ni, (!empty && status_o) |-> end_of_run_o, "lone error beat")
  `RMVP_NEVER(a_err_nz, clk_i, rst_ni, !empty && status_o && (|{out_index_o, out_value_o}), "err data")
  `RMVP_NEVER(a_cq_full_empty, clk_i, rst_ni, cq_stat.full && cq_stat.empty, "cmd queue state")
  `RMVP_ASSERT(a_full_after_push, clk_i, rst_ni, $rose(full) |-> $past(push), "full without push")

endmodule

`default_nettype wire

/* tb/sv/tb_rotation_matrix_vector_projection.sv */
`timescale 1ns / 1ps
// Testbench for rotation_matrix_vector_projection: coefficient/vector beats in,
// projected components out, checked against a behavioral matrix-vector model.
// Depends on rmvp_pkg and the rotation_matrix_vector_projection RTL.

module tb_rotation_matrix_vector_projection;
  import rmvp_pkg::*;

  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_BEATS = 240;

  class projection_scoreboard;
    logic signed [COEF_W-1:0]     coef_mem [COEF_DEPTH];
    logic signed [DATA_WIDTH-1:0] vec_mem  [DIM];
    bit                           loaded;
    logic [DIMS_W-1:0]            dims_reg;
    result_t                      component_q [$];
    int                           mismatches;

    function new();
      loaded     = 1'b0;
      dims_reg   = DIMS_RESET;
      mismatches = 0;
    endfunction

    function void write_dims(logic [DIMS_W-1:0] v);
      dims_reg = v;
    endfunction

    function int dims_in_use();
      if (dims_reg == 0) return 1;
      if (dims_reg > DIMS_MAX) return DIM;
      return int'(dims_reg);
    endfunction

    function int pending();
      return component_q.size();
    endfunction

    function void note_beat(req_e op, logic [FIELD_IDX_W-1:0] row,
                            logic [FIELD_IDX_W-1:0] col,
                            logic signed [COEF_W-1:0] value, logic last);
      result_t r;
      longint  acc;
      int      n;
      if (op == REQ_COEF) begin
        if (row < IDX_LIMIT && col < IDX_LIMIT) begin
          coef_mem[row * DIM + col] = value;
          loaded = 1'b1;
        end
        return;
      end
      if (col < IDX_LIMIT) vec_mem[col] = value[DATA_WIDTH-1:0];
      if (!last) return;
      if (!loaded) begin
        r.index      = '0;
        r.value      = '0;
        r.status     = STATUS_NOT_LOADED;
        r.end_of_run = 1'b1;
        component_q  = {component_q, r};
        return;
      end
      n = dims_in_use();
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++)
          acc += longint'(coef_mem[i * DIM + j]) * longint'(vec_mem[j]);
        r.index      = FIELD_IDX_W'(i);
        r.value      = acc[OUT_W-1:0];
        r.status     = STATUS_OK;
        r.end_of_run = (i == n - 1);
        component_q  = {component_q, r};
      end
    endfunction

    function void check_result(logic [FIELD_IDX_W-1:0] idx, logic [OUT_W-1:0] val,
                               logic st, logic eor);
      result_t exp_r;
      if (component_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat index=%0d value=%0d status=%0b eor=%0b",
                   $realtime, idx, $signed(val), st, eor);
        return;
      end
      exp_r = component_q.pop_front();
      if (idx !== exp_r.index || val !== exp_r.value || st !== exp_r.status ||
          eor !== exp_r.end_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b (idx/val/st/eor)",
                   $realtime, exp_r.index, $signed(exp_r.value), exp_r.status,
                   exp_r.end_of_run, idx, $signed(val), st, eor);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [DIMS_W-1:0]             cfg_wdata_i;
  logic                          push;
  wire                           full;
  logic                          req_type_i;
  logic [FIELD_IDX_W-1:0]        row_i;
  logic [FIELD_IDX_W-1:0]        col_i;
  logic signed [COEF_W-1:0]      value_i;
  logic                          last_i;
  wire                           empty;
  logic                          pop;
  wire [FIELD_IDX_W-1:0]         out_index_o;
  wire signed [OUT_W-1:0]        out_value_o;
  wire                           status_o;
  wire                           end_of_run_o;

  projection_scoreboard sb = new();
  bit idle_on      = 1'b1;
  bit hold_results = 1'b0;
  int beats_sent   = 0;

  rotation_matrix_vector_projection uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .last_i       (last_i),
    .empty        (empty),
    .pop          (pop),
    .out_index_o  (out_index_o),
    .out_value_o  (out_value_o),
    .status_o     (status_o),
    .end_of_run_o (end_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [COEF_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // every call starts and ends at a falling edge
  task automatic send_beat(req_e op, logic [FIELD_IDX_W-1:0] row,
                           logic [FIELD_IDX_W-1:0] col,
                           logic signed [COEF_W-1:0] value, logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    push       <= 1'b1;
    req_type_i <= op;
    row_i      <= row;
    col_i      <= col;
    value_i    <= value;
    last_i     <= last;
    do @(posedge clk_i); while (full);
    sb.note_beat(op, row, col, value, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_beat(REQ_VEC, 6'($urandom), 6'($urandom), pick_value(), 1'b0);
    else
      send_beat(REQ_COEF, 6'($urandom), 6'($urandom), pick_value(), 1'($urandom));
  endtask

  task automatic quiesce();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_dims(logic [DIMS_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.write_dims(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_block(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        send_beat(REQ_COEF, 6'(i), 6'(j), pick_value(), 1'($urandom));
  endtask

  // elements of one vector; noisy mode may shuffle, inject stray beats and end early
  task automatic run_vector(int n, bit noisy);
    int order [DIM];
    int k;
    int tmp;
    int pick;
    int stop;
    for (k = 0; k < n; k++) order[k] = k;
    if (noisy && $urandom_range(0, 1) == 0)
      for (k = n - 1; k > 0; k--) begin
        pick        = $urandom_range(0, k);
        tmp         = order[k];
        order[k]    = order[pick];
        order[pick] = tmp;
      end
    stop = n - 1;
    if (noisy && $urandom_range(0, 7) == 0) stop = $urandom_range(0, n - 1);
    for (k = 0; k <= stop; k++) begin
      if (noisy && $urandom_range(0, 5) == 0) send_noise();
      send_beat(REQ_VEC, 6'($urandom), 6'(order[k]), pick_value(), k == stop);
    end
  endtask

  task automatic random_phase();
    logic [DIMS_W-1:0] cfg;
    int                n;
    case ($urandom_range(0, 9))
      0:       cfg = 7'd0;
      default: cfg = 7'($urandom_range(1, 8));
    endcase
    quiesce();
    write_dims(cfg);
    n = sb.dims_in_use();
    load_block(n);
    repeat ($urandom_range(1, 4)) run_vector(n, 1'b1);
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
        if (rst_ni && !empty)
          sb.check_result(out_index_o, out_value_o, status_o, end_of_run_o);
      end
    end
  end

  initial begin
    int base;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    push        = 1'b0;
    req_type_i  = 1'b0;
    row_i       = '0;
    col_i       = '0;
    value_i     = '0;
    last_i      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no coefficient yet: error beats
    send_beat(REQ_VEC, 6'd0, 6'd0, 16'sd5, 1'b0);
    send_beat(REQ_VEC, 6'h3f, 6'h3f, -16'sd1, 1'b1);
    send_beat(REQ_VEC, 6'd0, 6'd1, 16'sh7fff, 1'b1);

    quiesce();
    write_dims(7'd1);
    send_beat(REQ_COEF, 6'd0, 6'd0, 16'sh8000, 1'b1);
    send_beat(REQ_VEC, 6'h2a, 6'd0, 16'sh8000, 1'b1);
    send_beat(REQ_COEF, 6'd0, 6'd0, 16'sh7fff, 1'b0);
    send_beat(REQ_VEC, 6'd0, 6'd0, 16'sh7fff, 1'b1);
    send_beat(REQ_VEC, 6'd0, 6'd0, 16'sh8000, 1'b1);

    quiesce();
    write_dims(7'd0);
    send_beat(REQ_VEC, 6'd0, 6'd0, 16'sd1, 1'b1);

    quiesce();
    write_dims(7'd2);
    send_beat(REQ_COEF, 6'd0, 6'd0, 16'sh8000, 1'b0);
    send_beat(REQ_COEF, 6'd0, 6'd1, 16'sh8000, 1'b0);
    send_beat(REQ_COEF, 6'd1, 6'd0, 16'sh7fff, 1'b0);
    send_beat(REQ_COEF, 6'd1, 6'd1, -16'sd1, 1'b0);
    send_beat(REQ_VEC, 6'd0, 6'd0, 16'sh8000, 1'b0);
    send_beat(REQ_VEC, 6'h15, 6'd1, 16'sh8000, 1'b1);
    send_beat(REQ_COEF, 6'h3f, 6'h3f, 16'sh5555, 1'b0);
    send_beat(REQ_VEC, 6'd0, 6'h3f, 16'sh2aaa, 1'b0);
    send_beat(REQ_VEC, 6'd0, 6'd1, 16'sd7, 1'b1);

    // 8x8 matrix, then hold the result side while beats keep coming
    quiesce();
    write_dims(7'd8);
    load_block(8);
    run_vector(8, 1'b0);
    run_vector(8, 1'b0);
    hold_results = 1'b1;
    repeat (30) send_beat(REQ_VEC, 6'($urandom), 6'($urandom), pick_value(), 1'b0);

    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) random_phase();

    quiesce();
    idle_on = 1'b0;
    write_dims(7'd3);
    load_block(3);
    repeat (3) run_vector(3, 1'b0);
    quiesce();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
